// ===== sv/stt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stt_pkg - shared types and constants of the source text tokeniser
// Token record, push bundle, scan modes, kind codes and character tests.
// ---------------------------------------------------------------------------
package stt_pkg;

	localparam int OFFSET_BITS      = 32;
	localparam int LENGTH_BITS      = 16;
	localparam int KEYWORD_CHARS    = 6;
	localparam int FLOAT_INT_DIGITS = 309;

	localparam int KW_W    = 8 * KEYWORD_CHARS;
	localparam int LEN_EXT = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
	localparam int SIG_W   = 10;

	typedef enum logic [2:0] {
		M_IDLE, M_MINUS, M_WORD, M_NUMBER, M_STRING, M_GARBAGE
	} scan_mode_t;

	localparam logic [4:0] K_END   = 5'd0;
	localparam logic [4:0] K_MINUS = 5'd12;
	localparam logic [4:0] K_ARROW = 5'd13;
	localparam logic [4:0] K_IDENT = 5'd14;
	localparam logic [4:0] K_KW0   = 5'd15;
	localparam logic [4:0] K_INT   = 5'd26;
	localparam logic [4:0] K_DEC   = 5'd27;
	localparam logic [4:0] K_STR   = 5'd28;
	localparam logic [4:0] K_GARB  = 5'd29;

	// number and string flag bits
	localparam int F_POINT = 0;
	localparam int F_FRAC  = 1;
	localparam int F_OVER  = 2;
	localparam int F_ESC   = 3;

	localparam int NUM_KW = 11;
	localparam logic [63:0] KW_PACK [0:NUM_KW-1] = '{
		64'h74727565, 64'h66616c7365, 64'h693634, 64'h663634, 64'h626f6f6c,
		64'h737472696e67, 64'h666e, 64'h6c6574, 64'h72657475726e, 64'h6966,
		64'h656c7365
	};
	localparam int KW_LEN [0:NUM_KW-1] = '{4, 5, 3, 3, 4, 6, 2, 3, 6, 2, 4};

	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] off;
		logic [15:0] len;
		logic [23:0] line;
		logic [15:0] col;
		logic        last;
	} token_t;

	typedef struct packed {
		logic   v0;
		logic   v1;
		token_t t0;
		token_t t1;
	} push_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	// zero when the byte is no single-character punctuator
	function automatic logic [4:0] punct_kind(input logic [7:0] b);
		logic [4:0] k;
		case (b)
			"+": k = 5'd1;
			"*": k = 5'd2;
			"/": k = 5'd3;
			":": k = 5'd4;
			";": k = 5'd5;
			"=": k = 5'd6;
			"(": k = 5'd7;
			")": k = 5'd8;
			"{": k = 5'd9;
			"}": k = 5'd10;
			",": k = 5'd11;
			default: k = K_END;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== sv/stt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stt_byte_if / stt_token_if - channels of the source text tokeniser
// Valid/ready channels for source bytes and for tokens.
// ---------------------------------------------------------------------------
interface stt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       end_of_input;
	modport source (output valid, source_byte, end_of_input, input ready);
	modport sink (input valid, source_byte, end_of_input, output ready);
endinterface

interface stt_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [31:0] start_offset;
	logic [15:0] text_length;
	logic [23:0] start_line;
	logic [15:0] start_column;
	logic        last_of_run;
	modport source (output valid, token_kind, start_offset, text_length, start_line,
		start_column, last_of_run, input ready);
	modport sink (input valid, token_kind, start_offset, text_length, start_line,
		start_column, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/stt_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stt_scanner - input register and scanner state
// Holds one byte beat, updates the scan state and yields up to two tokens.
// ---------------------------------------------------------------------------
module stt_scanner import stt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	stt_byte_if.sink  in_bytes,
	input  wire logic space_ok,
	output push_t     push
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;
	logic       fire;

	scan_mode_t             mode_q, mode_d;
	logic [OFFSET_BITS-1:0] offset_q, offset_d, org_off_q, org_off_d;
	logic [23:0]            line_q, line_d, org_line_q, org_line_d;
	logic [15:0]            col_q, col_d, org_col_q, org_col_d;
	logic [LENGTH_BITS-1:0] tlen_q, tlen_d;
	logic [KW_W-1:0]        kw_q, kw_d;
	logic                   wtl_q, wtl_d;
	logic [63:0]            ival_q, ival_d;
	logic [3:0]             flags_q, flags_d;
	logic [SIG_W-1:0]       sig_q, sig_d;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	assign fire           = valid_s1 && space_ok;
	assign in_bytes.ready = !valid_s1 || space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_bytes.valid && in_bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_bytes.valid && in_bytes.ready) begin
			byte_s1 <= in_bytes.source_byte;
			eoi_s1  <= in_bytes.end_of_input;
		end
	end

	function automatic token_t mk_tok(input logic [4:0] k, input logic [OFFSET_BITS-1:0] o,
		input logic [LEN_EXT-1:0] l, input logic [23:0] ln, input logic [15:0] c);
		token_t t;
		t.kind = k;
		t.off  = 32'(o);
		t.len  = (l > LEN_EXT'(16'hFFFF)) ? 16'hFFFF : 16'(l);
		t.line = ln;
		t.col  = c;
		t.last = 1'b0;
		return t;
	endfunction

	// keyword lookup over the held window
	logic [4:0] word_kind;
	always_comb begin
		word_kind = K_IDENT;
		if (!wtl_q) begin
			for (int i = NUM_KW - 1; i >= 0; i--) begin
				if (tlen_q == LENGTH_BITS'(KW_LEN[i]) && kw_q == KW_W'(KW_PACK[i]))
					word_kind = K_KW0 + 5'(i);
			end
		end
	end

	logic [4:0] num_kind;
	always_comb begin
		if (flags_q[F_POINT]) begin
			if (!flags_q[F_FRAC] || sig_q > SIG_W'(FLOAT_INT_DIGITS)) num_kind = K_GARB;
			else num_kind = K_DEC;
		end else begin
			num_kind = flags_q[F_OVER] ? K_GARB : K_INT;
		end
	end

	// token that closing the pending run gives
	token_t fin_tok;
	always_comb begin
		logic [4:0]         k;
		logic [LEN_EXT-1:0] l;
		l = LEN_EXT'(tlen_q);
		case (mode_q)
			M_MINUS: begin
				k = K_MINUS;
				l = LEN_EXT'(1);
			end
			M_WORD:   k = word_kind;
			M_NUMBER: k = num_kind;
			M_STRING: begin
				k = K_GARB;
				if (flags_q[F_ESC] && tlen_q < LEN_MAX) l = LEN_EXT'(tlen_q) + LEN_EXT'(1);
			end
			default: k = K_GARB;
		endcase
		fin_tok = mk_tok(k, org_off_q, l, org_line_q, org_col_q);
	end

	// digit accumulation
	logic [3:0]  dig;
	logic [67:0] ten_v;
	assign dig   = 4'(byte_s1 - 8'd48);
	assign ten_v = {1'b0, ival_q, 3'b0} + {3'b0, ival_q, 1'b0} + 68'(dig);

	logic [4:0] pk;
	assign pk = punct_kind(byte_s1);

	logic   first_v, second_v;
	token_t first_t, second_t;

	always_comb begin
		logic do_fin, do_beg;
		mode_d = mode_q;  offset_d = offset_q;  line_d = line_q;  col_d = col_q;
		org_off_d = org_off_q;  org_line_d = org_line_q;  org_col_d = org_col_q;
		tlen_d = tlen_q;  kw_d = kw_q;  wtl_d = wtl_q;  ival_d = ival_q;
		flags_d = flags_q;  sig_d = sig_q;
		first_v = 1'b0;  second_v = 1'b0;
		first_t = fin_tok;  second_t = fin_tok;
		do_fin = 1'b0;  do_beg = 1'b0;

		if (eoi_s1 || byte_s1 == 8'd0) begin
			first_v  = (mode_q != M_IDLE);
			second_v = 1'b1;
			second_t = mk_tok(K_END, offset_q, '0, line_q, col_q);
			mode_d = M_IDLE;  offset_d = '0;  line_d = 24'd1;  col_d = 16'd1;
			org_off_d = '0;  org_line_d = '0;  org_col_d = '0;  tlen_d = '0;
			kw_d = '0;  wtl_d = 1'b0;  ival_d = '0;  flags_d = '0;  sig_d = '0;
		end else begin
			case (mode_q)
				M_MINUS: begin
					if (byte_s1 == ">") begin
						second_v = 1'b1;
						second_t = mk_tok(K_ARROW, org_off_q, LEN_EXT'(2), org_line_q, org_col_q);
						mode_d = M_IDLE;
					end else begin
						do_fin = 1'b1;  do_beg = 1'b1;
					end
				end
				M_WORD: begin
					if (is_alpha(byte_s1) || is_digit(byte_s1) || byte_s1 == "_") begin
						if (tlen_q < LENGTH_BITS'(KEYWORD_CHARS)) kw_d = {kw_q[KW_W-9:0], byte_s1};
						else wtl_d = 1'b1;
						if (tlen_q < LEN_MAX) tlen_d = tlen_q + 1'b1;
					end else begin
						do_fin = 1'b1;  do_beg = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_digit(byte_s1)) begin
						if (flags_q[F_POINT]) begin
							flags_d[F_FRAC] = 1'b1;
						end else begin
							if (!flags_q[F_OVER]) begin
								if (ten_v > 68'h7FFF_FFFF_FFFF_FFFF) flags_d[F_OVER] = 1'b1;
								else ival_d = ten_v[63:0];
							end
							if ((dig != 4'd0 || sig_q != '0) && sig_q != '1) sig_d = sig_q + 1'b1;
						end
						if (tlen_q < LEN_MAX) tlen_d = tlen_q + 1'b1;
					end else if (byte_s1 == "." && !flags_q[F_POINT]) begin
						flags_d[F_POINT] = 1'b1;
						if (tlen_q < LEN_MAX) tlen_d = tlen_q + 1'b1;
					end else begin
						do_fin = 1'b1;  do_beg = 1'b1;
					end
				end
				M_STRING: begin
					if (flags_q[F_ESC]) begin
						flags_d[F_ESC] = 1'b0;
						if (tlen_q < LEN_MAX) tlen_d = tlen_q + 1'b1;
					end else if (byte_s1 == "\"") begin
						second_v = 1'b1;
						second_t = mk_tok(K_STR, org_off_q + 1'b1, LEN_EXT'(tlen_q),
							org_line_q, org_col_q);
						mode_d = M_IDLE;
					end else begin
						if (byte_s1 == "\\") flags_d[F_ESC] = 1'b1;
						if (tlen_q < LEN_MAX) tlen_d = tlen_q + 1'b1;
					end
				end
				M_GARBAGE: begin
					if (is_ws(byte_s1)) do_fin = 1'b1;
					else if (tlen_q < LEN_MAX) tlen_d = tlen_q + 1'b1;
				end
				default: do_beg = 1'b1;
			endcase

			if (do_fin) begin
				first_v = 1'b1;
				mode_d  = M_IDLE;
			end
			if (do_beg && !is_ws(byte_s1)) begin
				org_off_d = offset_q;  org_line_d = line_q;  org_col_d = col_q;
				tlen_d = LENGTH_BITS'(1);
				if (pk != K_END) begin
					second_v = 1'b1;
					second_t = mk_tok(pk, offset_q, LEN_EXT'(1), line_q, col_q);
				end else if (byte_s1 == "-") begin
					mode_d = M_MINUS;
				end else if (is_alpha(byte_s1) || byte_s1 == "_") begin
					mode_d = M_WORD;
					kw_d   = KW_W'(byte_s1);
					wtl_d  = 1'b0;
				end else if (is_digit(byte_s1)) begin
					mode_d  = M_NUMBER;
					flags_d = '0;
					ival_d  = 64'(dig);
					sig_d   = (dig != 4'd0) ? SIG_W'(1) : '0;
				end else if (byte_s1 == "\"") begin
					mode_d  = M_STRING;
					tlen_d  = '0;
					flags_d = '0;
				end else begin
					mode_d = M_GARBAGE;
				end
			end

			// advance position
			if (byte_s1 == 8'd10) begin
				if (line_q != 24'hFFFFFF) line_d = line_q + 1'b1;
				col_d = 16'd1;
			end else if (col_q != 16'hFFFF) begin
				col_d = col_q + 1'b1;
			end
			offset_d = offset_q + 1'b1;
		end
	end

	always_comb begin
		push = '0;
		if (first_v) begin
			push.v0 = fire;
			push.t0 = first_t;
			push.v1 = fire && second_v;
			push.t1 = second_t;
			push.t0.last = !second_v;
			push.t1.last = 1'b1;
		end else begin
			push.v0 = fire && second_v;
			push.t0 = second_t;
			push.t0.last = 1'b1;
			push.t1 = second_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;  offset_q <= '0;  line_q <= 24'd1;  col_q <= 16'd1;
			org_off_q <= '0;  org_line_q <= '0;  org_col_q <= '0;  tlen_q <= '0;
			kw_q <= '0;  wtl_q <= 1'b0;  ival_q <= '0;  flags_q <= '0;  sig_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;  offset_q <= offset_d;  line_q <= line_d;  col_q <= col_d;
			org_off_q <= org_off_d;  org_line_q <= org_line_d;  org_col_q <= org_col_d;
			tlen_q <= tlen_d;  kw_q <= kw_d;  wtl_q <= wtl_d;  ival_q <= ival_d;
			flags_q <= flags_d;  sig_q <= sig_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/stt_token_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stt_token_fifo - four-entry token queue
// Takes up to two tokens a cycle, pops one a cycle when the sink is ready.
// ---------------------------------------------------------------------------
module stt_token_fifo import stt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  push_t        push,
	output logic         space_ok,
	stt_token_if.source  tokens
);

	token_t     mem_q [0:3];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic       pop;
	logic [1:0] npush;

	assign space_ok = cnt_q <= 3'd2;
	assign pop      = tokens.valid && tokens.ready;
	assign npush    = 2'(push.v0) + 2'(push.v1);

	always_ff @(posedge clk) begin
		if (push.v0) mem_q[wr_q] <= push.t0;
		if (push.v1) mem_q[wr_q + 2'd1] <= push.t1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + npush;
			rd_q  <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(npush) - 3'(pop);
		end
	end

	assign tokens.valid        = cnt_q != 3'd0;
	assign tokens.token_kind   = mem_q[rd_q].kind;
	assign tokens.start_offset = mem_q[rd_q].off;
	assign tokens.text_length  = mem_q[rd_q].len;
	assign tokens.start_line   = mem_q[rd_q].line;
	assign tokens.start_column = mem_q[rd_q].col;
	assign tokens.last_of_run  = mem_q[rd_q].last;

endmodule
`default_nettype wire

// ===== sv/source_text_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// source_text_tokenizer - streaming tokeniser for source text
// Turns a byte stream into tokens with kind, offset, length, line and column.
// ---------------------------------------------------------------------------
//  channel    dir  beat carries
//  in_bytes   in   source_byte, end_of_input
//  tokens     out  token_kind, start_offset, text_length, start_line,
//                  start_column, last_of_run
//
//  One byte beat a cycle while the queue has room: the scanner register
//  takes a beat, short logic updates the scan state and writes zero to two
//  tokens into a four-entry queue, from which they are offered. The scanner
//  register holds its beat while the queue has fewer than two free slots;
//  the queue drain of one token a cycle sets the sustained rate. Reset
//  clears scan state and the queue at once; a stalled token sink holds the
//  head token and backs up into in_bytes.
// ---------------------------------------------------------------------------
module source_text_tokenizer import stt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	stt_byte_if.sink    in_bytes,
	stt_token_if.source tokens
);

	push_t push;
	logic  space_ok;

	// scan one byte per beat
	stt_scanner u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_bytes (in_bytes),
		.space_ok (space_ok),
		.push     (push)
	);

	// queue tokens towards the sink
	stt_token_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.tokens   (tokens)
	);

endmodule
`default_nettype wire

// ===== sv/stt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stt_checker - port checks of the tokeniser
// Watches the token channel for malformed beats.
// ---------------------------------------------------------------------------
module stt_checker import stt_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [4:0]  kind,
	input wire logic [15:0] len,
	input wire logic [23:0] line,
	input wire logic [15:0] col,
	input wire logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("token beat dropped while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind <= K_GARB)
		else $error("token kind out of range");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == K_END |-> last && len == 16'd0)
		else $error("end token malformed");

	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line != 24'd0 && col != 16'd0)
		else $error("token position zero");

endmodule

bind source_text_tokenizer stt_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (tokens.valid),
	.out_ready (tokens.ready),
	.kind      (tokens.token_kind),
	.len       (tokens.text_length),
	.line      (tokens.start_line),
	.col       (tokens.start_column),
	.last      (tokens.last_of_run)
);
`default_nettype wire
